>>> sv/tsr_pkg.sv
// ---------------------------------------------------------------------------
// Track spike remover package
// Shared widths, register indexes, record and job types and state encodings.
// ---------------------------------------------------------------------------
package tsr_pkg;

    localparam int FRAME_BITS    = 20;
    localparam int FRACTION_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int THR_W         = 24;
    localparam int MODE_W        = 2;
    localparam int IDX_W         = 2;
    localparam int QUEUE_DEPTH   = 2;

    // Quotient holds one integer bit, so the fraction may reach exactly one.
    localparam int QUO_W   = FRACTION_BITS + 1;
    localparam int REM_W   = FRAME_BITS + 1;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PIXEL_THR  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SCALE_THR  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_TRACK_MODE = IDX_W'(2);

    localparam logic [THR_W-1:0]  PIXEL_THR_RESET  = THR_W'(256);
    localparam logic [THR_W-1:0]  SCALE_THR_RESET  = THR_W'(655);
    localparam logic [MODE_W-1:0] TRACK_MODE_RESET = MODE_W'(0);

    // Mode bits.
    localparam int MODE_SCALE_BIT = 0;
    localparam int MODE_ROT_BIT   = 1;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        word_t                 x;
        word_t                 y;
        word_t                 ax;
        word_t                 ay;
        word_t                 sx;
        word_t                 sy;
        word_t                 rot;
        logic                  locked;
    } rec_t;

    // One unit of work for the back end.
    typedef struct packed {
        rec_t prev;
        rec_t mid;
        rec_t nxt;
        logic do_clean;
        logic emit_mid;
        logic emit_last;
    } job_t;

    typedef struct packed {
        logic [THR_W-1:0]  pixel_thr;
        logic [THR_W-1:0]  scale_thr;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_TWO
    } fill_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_MUL,
        BK_DECIDE,
        BK_EMIT_MID,
        BK_EMIT_LAST
    } back_state_t;

    // Multiplier schedule: interpolation products, threshold square, distances.
    typedef enum logic [3:0] {
        ST_EX,
        ST_EY,
        ST_ESX,
        ST_ESY,
        ST_EROT,
        ST_THR,
        ST_SEX,
        ST_SEY,
        ST_SPX,
        ST_SPY,
        ST_SNX,
        ST_SNY,
        ST_DRAIN
    } mul_step_t;

endpackage

>>> sv/tsr_if.sv
// ---------------------------------------------------------------------------
// Track spike remover channels
// Keyframe input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface tsr_key_if;
    import tsr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FRAME_BITS-1:0] frame_number;
    word_t                 pos_x;
    word_t                 pos_y;
    word_t                 anchor_in_x;
    word_t                 anchor_in_y;
    word_t                 scale_in_x;
    word_t                 scale_in_y;
    word_t                 rotation_in;
    logic                  is_locked;
    logic                  is_final;

    modport source (
        output valid, frame_number, pos_x, pos_y, anchor_in_x, anchor_in_y,
               scale_in_x, scale_in_y, rotation_in, is_locked, is_final,
        input  ready
    );
    modport sink (
        input  valid, frame_number, pos_x, pos_y, anchor_in_x, anchor_in_y,
               scale_in_x, scale_in_y, rotation_in, is_locked, is_final,
        output ready
    );
endinterface

interface tsr_res_if;
    import tsr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FRAME_BITS-1:0] out_frame;
    word_t                 out_x;
    word_t                 out_y;
    word_t                 out_anchor_x;
    word_t                 out_anchor_y;
    word_t                 out_scale_x;
    word_t                 out_scale_y;
    word_t                 out_rotation;
    logic                  out_last;

    modport source (
        output valid, out_frame, out_x, out_y, out_anchor_x, out_anchor_y,
               out_scale_x, out_scale_y, out_rotation, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_frame, out_x, out_y, out_anchor_x, out_anchor_y,
               out_scale_x, out_scale_y, out_rotation, out_last,
        output ready
    );
endinterface

>>> sv/track_spike_remover.sv
// ---------------------------------------------------------------------------
// Track spike remover
// Removes single-keyframe spikes from a frame-sorted track by comparing each
// unlocked inner record with the value interpolated between its raw neighbours.
//
//   Channel    Dir  Handshake           Content
//   keyframe   in   valid/ready         one track keyframe
//   result     out  valid/ready         one cleaned record, out_last on final
//   wr_*       in   write enable only   threshold and mode registers
//
// A record that is tested goes through set-up, the bit-serial division of the
// frame fraction, the schedule of the shared multiplier, the decision and
// output. Other records skip the division and the multiplier.
// A two-entry job queue lets the front end keep taking keyframes while the
// back end works or the result is stalled. Reset clears the window fill,
// the queue and the output valid; configuration returns to its reset values.
// ---------------------------------------------------------------------------
module track_spike_remover (
    input  logic                      clk,
    input  logic                      rst_n,
    tsr_key_if.sink                   keyframe,
    tsr_res_if.source                 result,
    input  logic                      wr_en,
    input  logic [tsr_pkg::IDX_W-1:0] wr_index,
    input  logic [tsr_pkg::THR_W-1:0] wr_data
);
    import tsr_pkg::*;

    cfg_t cfg_reg;
    logic push;
    job_t push_job;
    logic q_full;
    logic q_empty;
    logic pop;
    job_t q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_thr <= PIXEL_THR_RESET;
            cfg_reg.scale_thr <= SCALE_THR_RESET;
            cfg_reg.mode      <= TRACK_MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PIXEL_THR:  cfg_reg.pixel_thr <= wr_data;
                REG_SCALE_THR:  cfg_reg.scale_thr <= wr_data;
                REG_TRACK_MODE: cfg_reg.mode      <= wr_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    tsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .keyframe (keyframe),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    tsr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_job),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .rdata (q_head)
    );

    tsr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> sv/tsr_fifo.sv
// ---------------------------------------------------------------------------
// Track spike remover job queue
// Short register queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module tsr_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tsr_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tsr_pkg::job_t rdata
);
    import tsr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Storage is written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/tsr_front.sv
// ---------------------------------------------------------------------------
// Track spike remover front end
// Accepts keyframes, keeps the two-record window and queues output jobs.
// ---------------------------------------------------------------------------
module tsr_front (
    input  logic          clk,
    input  logic          rst_n,
    tsr_key_if.sink       keyframe,
    input  logic          q_full,
    output logic          push,
    output tsr_pkg::job_t job
);
    import tsr_pkg::*;

    fill_t fill_reg;
    fill_t fill_next;
    rec_t  prev_reg;
    rec_t  mid_reg;
    rec_t  cur;
    logic  accept;
    logic  fin;
    logic  load_mid;
    logic  shift_win;

    assign keyframe.ready = !q_full;
    assign accept         = keyframe.valid && !q_full;
    assign fin            = keyframe.is_final;

    // Incoming record.
    always_comb
    begin
        cur.frame  = keyframe.frame_number;
        cur.x      = keyframe.pos_x;
        cur.y      = keyframe.pos_y;
        cur.ax     = keyframe.anchor_in_x;
        cur.ay     = keyframe.anchor_in_y;
        cur.sx     = keyframe.scale_in_x;
        cur.sy     = keyframe.scale_in_y;
        cur.rot    = keyframe.rotation_in;
        cur.locked = keyframe.is_locked;
    end

    // Window fill: next state.
    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            unique case (fill_reg)
                FILL_EMPTY: fill_next = fin ? FILL_EMPTY : FILL_ONE;
                default:    fill_next = fin ? FILL_EMPTY : FILL_TWO;
            endcase
        end
    end

    // Window fill: job and window update.
    always_comb
    begin
        push      = 1'b0;
        load_mid  = 1'b0;
        shift_win = 1'b0;
        job.prev      = prev_reg;
        job.mid       = mid_reg;
        job.nxt       = cur;
        job.do_clean  = 1'b0;
        job.emit_mid  = 1'b1;
        job.emit_last = fin;
        if (accept)
        begin
            unique case (fill_reg)
                FILL_EMPTY:
                begin
                    push         = fin;
                    load_mid     = !fin;
                    job.emit_mid = 1'b0;
                end
                FILL_ONE:
                begin
                    push      = 1'b1;
                    shift_win = !fin;
                end
                default:
                begin
                    push         = 1'b1;
                    shift_win    = !fin;
                    job.do_clean = !mid_reg.locked;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= FILL_EMPTY;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Raw window: the middle record moves back unchanged.
    always_ff @(posedge clk)
    begin
        if (load_mid)
        begin
            mid_reg <= cur;
        end
        else if (shift_win)
        begin
            prev_reg <= mid_reg;
            mid_reg  <= cur;
        end
    end

endmodule

>>> sv/tsr_back.sv
// ---------------------------------------------------------------------------
// Track spike remover back end
// Serial division for the interpolation fraction, one shared multiplier for
// interpolation and squared distances, spike decision and result output.
// ---------------------------------------------------------------------------
module tsr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tsr_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  tsr_pkg::job_t q_head,
    output logic          pop,
    tsr_res_if.source     result
);
    import tsr_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    job_t        job_reg;

    logic [FRAME_BITS-1:0] span_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      cnt_reg;

    mul_step_t         step_reg;
    mul_step_t         pstep_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              psign_reg;
    word_t             ex_reg;
    word_t             ey_reg;
    word_t             esx_reg;
    word_t             esy_reg;
    word_t             erot_reg;
    logic [2*THR_W-1:0] thr2_reg;
    logic [SUM_W-1:0]  se_reg;
    logic [SUM_W-1:0]  sp_reg;
    logic [SUM_W-1:0]  sn_reg;

    logic  out_valid_reg;
    rec_t  out_rec_reg;
    logic  out_last_reg;
    logic  out_free;
    logic  load_mid;
    logic  load_last;

    // Absolute value of a 33-bit difference.
    function automatic logic [DATA_W:0] abs_diff(input word_t a, input word_t b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return d[DATA_W] ? (DATA_W+1)'(-d) : d;
    endfunction

    // Scalar three-way spike test.
    function automatic logic spike(input word_t p, input word_t c, input word_t n,
                                   input word_t e, input logic [THR_W-1:0] thr);
        logic [DATA_W:0] t;
        t = (DATA_W+1)'(thr);
        return (abs_diff(c, e) > t) && (abs_diff(c, p) > t) && (abs_diff(c, n) > t);
    endfunction

    assign out_free = !out_valid_reg || result.ready;

    // ---- Division set-up: span and clamped numerator ----
    logic signed [FRAME_BITS:0] span_full;
    logic signed [FRAME_BITS:0] num_full;
    logic [FRAME_BITS-1:0]      span_c;
    logic [FRAME_BITS-1:0]      num_c;

    always_comb
    begin
        span_full = {1'b0, job_reg.nxt.frame} - {1'b0, job_reg.prev.frame};
        num_full  = {1'b0, job_reg.mid.frame} - {1'b0, job_reg.prev.frame};
        span_c    = (span_full < (FRAME_BITS+1)'(1)) ? FRAME_BITS'(1)
                    : span_full[FRAME_BITS-1:0];
        if (num_full[FRAME_BITS])
        begin
            num_c = '0;
        end
        else if (num_full[FRAME_BITS-1:0] > span_c)
        begin
            num_c = span_c;
        end
        else
        begin
            num_c = num_full[FRAME_BITS-1:0];
        end
    end

    // ---- One restoring division step ----
    logic [REM_W-1:0] rem_shift;
    logic             div_ge;

    always_comb
    begin
        rem_shift = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        div_ge    = rem_shift >= {1'b0, span_reg};
    end

    // ---- Multiplier operand selection ----
    logic signed [DATA_W:0] op_d;
    logic [DATA_W-1:0]      op_a;
    logic [DATA_W-1:0]      op_b;
    logic [DATA_W:0]        op_mag;
    logic [DATA_W-1:0]      t_ext;

    assign t_ext = DATA_W'(quo_reg);

    always_comb
    begin
        op_d = '0;
        op_b = t_ext;
        unique case (step_reg)
            ST_EX:   op_d = {job_reg.nxt.x[DATA_W-1], job_reg.nxt.x}
                            - {job_reg.prev.x[DATA_W-1], job_reg.prev.x};
            ST_EY:   op_d = {job_reg.nxt.y[DATA_W-1], job_reg.nxt.y}
                            - {job_reg.prev.y[DATA_W-1], job_reg.prev.y};
            ST_ESX:  op_d = {job_reg.nxt.sx[DATA_W-1], job_reg.nxt.sx}
                            - {job_reg.prev.sx[DATA_W-1], job_reg.prev.sx};
            ST_ESY:  op_d = {job_reg.nxt.sy[DATA_W-1], job_reg.nxt.sy}
                            - {job_reg.prev.sy[DATA_W-1], job_reg.prev.sy};
            ST_EROT: op_d = {job_reg.nxt.rot[DATA_W-1], job_reg.nxt.rot}
                            - {job_reg.prev.rot[DATA_W-1], job_reg.prev.rot};
            ST_THR:
            begin
                op_d = (DATA_W+1)'(cfg.pixel_thr);
                op_b = DATA_W'(cfg.pixel_thr);
            end
            ST_SEX:  op_d = {job_reg.mid.x[DATA_W-1], job_reg.mid.x}
                            - {ex_reg[DATA_W-1], ex_reg};
            ST_SEY:  op_d = {job_reg.mid.y[DATA_W-1], job_reg.mid.y}
                            - {ey_reg[DATA_W-1], ey_reg};
            ST_SPX:  op_d = {job_reg.mid.x[DATA_W-1], job_reg.mid.x}
                            - {job_reg.prev.x[DATA_W-1], job_reg.prev.x};
            ST_SPY:  op_d = {job_reg.mid.y[DATA_W-1], job_reg.mid.y}
                            - {job_reg.prev.y[DATA_W-1], job_reg.prev.y};
            ST_SNX:  op_d = {job_reg.mid.x[DATA_W-1], job_reg.mid.x}
                            - {job_reg.nxt.x[DATA_W-1], job_reg.nxt.x};
            ST_SNY:  op_d = {job_reg.mid.y[DATA_W-1], job_reg.mid.y}
                            - {job_reg.nxt.y[DATA_W-1], job_reg.nxt.y};
            default: op_d = '0;
        endcase
        op_mag = op_d[DATA_W] ? (DATA_W+1)'(-op_d) : op_d;
        op_a   = op_mag[DATA_W-1:0];
        // A square uses the magnitude twice.
        if (step_reg == ST_SEX || step_reg == ST_SEY || step_reg == ST_SPX ||
            step_reg == ST_SPY || step_reg == ST_SNX || step_reg == ST_SNY)
        begin
            op_b = op_a;
        end
    end

    // ---- Interpolated value from the registered product ----
    logic signed [PROD_W+1:0] sprod;
    logic signed [PROD_W+1:0] sprod_sh;
    word_t                    e_base;
    logic signed [DATA_W+1:0] e_full;
    word_t                    e_val;

    always_comb
    begin
        sprod    = psign_reg ? -$signed({2'b00, prod_reg}) : $signed({2'b00, prod_reg});
        sprod_sh = sprod >>> FRACTION_BITS;
        unique case (pstep_reg)
            ST_EX:   e_base = job_reg.prev.x;
            ST_EY:   e_base = job_reg.prev.y;
            ST_ESX:  e_base = job_reg.prev.sx;
            ST_ESY:  e_base = job_reg.prev.sy;
            default: e_base = job_reg.prev.rot;
        endcase
        e_full = {{2{e_base[DATA_W-1]}}, e_base} + sprod_sh[DATA_W+1:0];
        e_val  = e_full[DATA_W-1:0];
    end

    // ---- Spike decision ----
    rec_t cleaned;
    logic pos_spike;
    logic [SUM_W-1:0] thr2_ext;

    assign thr2_ext = SUM_W'(thr2_reg);

    always_comb
    begin
        cleaned   = job_reg.mid;
        pos_spike = (se_reg > thr2_ext) && (sp_reg > thr2_ext) && (sn_reg > thr2_ext);
        if (pos_spike)
        begin
            cleaned.x  = ex_reg;
            cleaned.y  = ey_reg;
            cleaned.ax = ex_reg;
            cleaned.ay = ey_reg;
        end
        if (cfg.mode[MODE_SCALE_BIT])
        begin
            if (spike(job_reg.prev.sx, job_reg.mid.sx, job_reg.nxt.sx, esx_reg,
                      cfg.scale_thr))
            begin
                cleaned.sx = esx_reg;
            end
            if (spike(job_reg.prev.sy, job_reg.mid.sy, job_reg.nxt.sy, esy_reg,
                      cfg.scale_thr))
            begin
                cleaned.sy = esy_reg;
            end
        end
        if (cfg.mode[MODE_ROT_BIT])
        begin
            if (spike(job_reg.prev.rot, job_reg.mid.rot, job_reg.nxt.rot, erot_reg,
                      cfg.pixel_thr))
            begin
                cleaned.rot = erot_reg;
            end
        end
    end

    // ---- Sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_PREP;
                end
            end
            BK_PREP:
            begin
                if (job_reg.do_clean)
                begin
                    state_next = BK_DIV;
                end
                else if (job_reg.emit_mid)
                begin
                    state_next = BK_EMIT_MID;
                end
                else
                begin
                    state_next = BK_EMIT_LAST;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                if (step_reg == ST_DRAIN)
                begin
                    state_next = BK_DECIDE;
                end
            end
            BK_DECIDE:    state_next = BK_EMIT_MID;
            BK_EMIT_MID:
            begin
                if (out_free)
                begin
                    state_next = job_reg.emit_last ? BK_EMIT_LAST : BK_IDLE;
                end
            end
            BK_EMIT_LAST:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:      state_next = BK_IDLE;
        endcase
    end

    // ---- Sequencer: outputs ----
    always_comb
    begin
        pop       = (state_reg == BK_IDLE) && !q_empty;
        load_mid  = (state_reg == BK_EMIT_MID) && out_free;
        load_last = (state_reg == BK_EMIT_LAST) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_mid || load_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- Datapath registers ----
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_head;
        end
        if (state_reg == BK_PREP)
        begin
            span_reg  <= span_c;
            rem_reg   <= REM_W'(num_c);
            quo_reg   <= '0;
            cnt_reg   <= '0;
            step_reg  <= ST_EX;
            pstep_reg <= ST_DRAIN;
            se_reg    <= '0;
            sp_reg    <= '0;
            sn_reg    <= '0;
        end
        if (state_reg == BK_DIV)
        begin
            rem_reg <= div_ge ? rem_shift - {1'b0, span_reg} : rem_shift;
            quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == BK_MUL)
        begin
            // Issue this step and retire the previous one.
            prod_reg  <= op_a * op_b;
            psign_reg <= op_d[DATA_W];
            pstep_reg <= step_reg;
            if (step_reg != ST_DRAIN)
            begin
                step_reg <= mul_step_t'(step_reg + 1'b1);
            end
            unique case (pstep_reg)
                ST_EX:   ex_reg   <= e_val;
                ST_EY:   ey_reg   <= e_val;
                ST_ESX:  esx_reg  <= e_val;
                ST_ESY:  esy_reg  <= e_val;
                ST_EROT: erot_reg <= e_val;
                ST_THR:  thr2_reg <= prod_reg[2*THR_W-1:0];
                ST_SEX, ST_SEY: se_reg <= se_reg + SUM_W'(prod_reg);
                ST_SPX, ST_SPY: sp_reg <= sp_reg + SUM_W'(prod_reg);
                ST_SNX, ST_SNY: sn_reg <= sn_reg + SUM_W'(prod_reg);
                default: ;
            endcase
        end
        if (state_reg == BK_DECIDE)
        begin
            job_reg.mid <= cleaned;
        end
        if (load_mid)
        begin
            out_rec_reg  <= job_reg.mid;
            out_last_reg <= 1'b0;
        end
        else if (load_last)
        begin
            out_rec_reg  <= job_reg.nxt;
            out_last_reg <= 1'b1;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_frame    = out_rec_reg.frame;
    assign result.out_x        = out_rec_reg.x;
    assign result.out_y        = out_rec_reg.y;
    assign result.out_anchor_x = out_rec_reg.ax;
    assign result.out_anchor_y = out_rec_reg.ay;
    assign result.out_scale_x  = out_rec_reg.sx;
    assign result.out_scale_y  = out_rec_reg.sy;
    assign result.out_rotation = out_rec_reg.rot;
    assign result.out_last     = out_last_reg;

endmodule
